/* rtl/hard_stop_homing_sequencer_top_defines.svh */
// Assertion macros for the homing sequencer
`ifndef HARD_STOP_HOMING_SEQUENCER_TOP_DEFINES_SVH
`define HARD_STOP_HOMING_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HSH_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hard stop homing check failed");

// next-cycle implication, checked outside reset
`define HSH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hard stop homing check failed");

`endif

/* rtl/hsh_pkg.sv */
// Types and constants shared by the homing sequencer
package hsh_pkg;

   localparam int DataWidth  = 32;
   localparam int StallTicks = 100;
   localparam int CountWidth = 8;
   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_SEARCH_VEL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_STALL_VEL  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_CENTER_EN  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_RETURN_EN  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_RETURN_TGT = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_RETURN_TOL = 3'd5;

   localparam logic [1:0] PHASE_INIT = 2'd0;
   localparam logic [1:0] PHASE_POS  = 2'd1;
   localparam logic [1:0] PHASE_NEG  = 2'd2;
   localparam logic [1:0] PHASE_CAL  = 2'd3;

   localparam logic [1:0] DRIVE_NONE = 2'd0;
   localparam logic [1:0] DRIVE_VEL  = 2'd1;
   localparam logic [1:0] DRIVE_POS  = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT = 4'b0001,
      ST_POS  = 4'b0010,
      ST_NEG  = 4'b0100,
      ST_CAL  = 4'b1000
   } state_type;

   typedef struct packed {
      logic                        restart;
      logic signed [DataWidth-1:0] joint_speed;
      logic signed [DataWidth-1:0] actuator_pos;
      logic signed [DataWidth-1:0] current_offset;
      logic                        halted;
      logic signed [DataWidth-1:0] joint_pos;
   } req_type;

   typedef struct packed {
      logic [1:0]                  phase;
      logic [1:0]                  drive_mode;
      logic signed [DataWidth-1:0] drive_command;
      logic                        offset_write;
      logic signed [DataWidth-1:0] new_offset;
      logic                        calibrated;
      logic                        done_res;
   } rsp_type;

endpackage

/* rtl/hard_stop_homing_sequencer_top.sv */
// Hard-stop homing sequencer: input register, one pass of logic, result register
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (req_type)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (rsp_type)
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// req passes both registers to rsp_valid; one transaction per cycle unless stalled.
// The sequencing state updates as a transaction leaves the input register.
// reset clears state, handshake flags and configuration registers synchronously.
// req_stall rises only while the input register is full and the result is stalled.
`include "hard_stop_homing_sequencer_top_defines.svh"

module hard_stop_homing_sequencer_top
   import hsh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]   csr_wdata
);

   logic [DataWidth-1:0]   search_vel_ff;
   logic [DataWidth-2:0]   stall_vel_ff;
   logic                   center_en_ff;
   logic                   return_en_ff;
   logic [DataWidth-1:0]   return_tgt_ff;
   logic [DataWidth-2:0]   return_tol_ff;

   logic                   in_valid_ff, in_valid_in;
   req_type                in_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   state_type              state_ff, state_in;
   logic signed [CountWidth-1:0] count_ff, count_in;
   logic [DataWidth-1:0]   pos_stop_ff, pos_stop_in;
   logic                   returned_ff, returned_in;
   logic                   cal_ff, cal_in;
   logic [DataWidth-1:0]   held_ff, held_in;

   logic                   out_load;
   logic                   fire;
   logic                   req_take;
   logic [DataWidth-1:0]   speed_mag;
   logic                   slow;
   logic [DataWidth-1:0]   mean_x;
   logic [DataWidth-1:0]   mean;
   logic [DataWidth-1:0]   ret_diff;
   logic signed [CountWidth-1:0] count_dec;
   state_type              state_cur;

   logic                   rsp_cal_phase;
   logic                   rsp_has_wr;
   logic                   rsp_no_drive;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_vel_ff <= '0;
         stall_vel_ff  <= '0;
         center_en_ff  <= 1'b0;
         return_en_ff  <= 1'b0;
         return_tgt_ff <= '0;
         return_tol_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEARCH_VEL: search_vel_ff <= csr_wdata;
            CSR_STALL_VEL:  stall_vel_ff  <= csr_wdata[DataWidth-2:0];
            CSR_CENTER_EN:  center_en_ff  <= csr_wdata[0];
            CSR_RETURN_EN:  return_en_ff  <= csr_wdata[0];
            CSR_RETURN_TGT: return_tgt_ff <= csr_wdata;
            CSR_RETURN_TOL: return_tol_ff <= csr_wdata[DataWidth-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      speed_mag = in_data_ff.joint_speed[DataWidth-1] ?
                  (DataWidth'(0) - in_data_ff.joint_speed) : in_data_ff.joint_speed;
      slow      = speed_mag < {1'b0, stall_vel_ff};
      mean_x    = in_data_ff.actuator_pos ^ pos_stop_ff;
      mean      = (in_data_ff.actuator_pos & pos_stop_ff) +
                  {mean_x[DataWidth-1], mean_x[DataWidth-1:1]};
      ret_diff  = ($signed(in_data_ff.joint_pos) >= $signed(return_tgt_ff)) ?
                  (in_data_ff.joint_pos - return_tgt_ff) :
                  (return_tgt_ff - in_data_ff.joint_pos);
      count_dec = count_ff - CountWidth'(1);

      state_cur   = in_data_ff.restart ? ST_INIT : state_ff;
      cal_in      = in_data_ff.restart ? 1'b0 : cal_ff;
      state_in    = state_cur;
      count_in    = count_ff;
      pos_stop_in = pos_stop_ff;
      returned_in = returned_ff;
      held_in     = held_ff;
      rsp_data_in = '0;

      unique case (state_cur)
         ST_INIT: begin
            held_in  = search_vel_ff;
            count_in = CountWidth'(StallTicks);
            state_in = ST_POS;
         end
         ST_POS: begin
            count_in = (slow && !in_data_ff.halted) ? count_dec : CountWidth'(StallTicks);
            if (count_in[CountWidth-1]) begin
               held_in = '0;
               if (!center_en_ff) begin
                  rsp_data_in.new_offset   = in_data_ff.current_offset - in_data_ff.actuator_pos;
                  rsp_data_in.offset_write = 1'b1;
                  cal_in   = 1'b1;
                  state_in = ST_CAL;
                  if (!return_en_ff) begin
                     returned_in = 1'b1;
                  end
               end else begin
                  pos_stop_in = in_data_ff.actuator_pos;
                  count_in    = CountWidth'(StallTicks);
                  held_in     = DataWidth'(0) - search_vel_ff;
                  state_in    = ST_NEG;
               end
            end
            rsp_data_in.drive_mode    = DRIVE_VEL;
            rsp_data_in.drive_command = held_in;
         end
         ST_NEG: begin
            count_in = slow ? count_dec : CountWidth'(StallTicks);
            if (count_in[CountWidth-1]) begin
               held_in = '0;
               rsp_data_in.new_offset   = in_data_ff.current_offset - mean;
               rsp_data_in.offset_write = 1'b1;
               cal_in   = 1'b1;
               state_in = ST_CAL;
               if (!return_en_ff) begin
                  returned_in = 1'b1;
               end
            end
            rsp_data_in.drive_mode    = DRIVE_VEL;
            rsp_data_in.drive_command = held_in;
         end
         ST_CAL: begin
            if (return_en_ff) begin
               if (ret_diff < {1'b0, return_tol_ff}) begin
                  returned_in = 1'b1;
               end
               rsp_data_in.drive_mode    = DRIVE_POS;
               rsp_data_in.drive_command = return_tgt_ff;
            end else begin
               rsp_data_in.drive_mode    = DRIVE_VEL;
               rsp_data_in.drive_command = held_ff;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      unique case (state_in)
         ST_INIT: rsp_data_in.phase = PHASE_INIT;
         ST_POS:  rsp_data_in.phase = PHASE_POS;
         ST_NEG:  rsp_data_in.phase = PHASE_NEG;
         ST_CAL:  rsp_data_in.phase = PHASE_CAL;
         default: rsp_data_in.phase = PHASE_INIT;
      endcase
      rsp_data_in.calibrated = cal_in;
      rsp_data_in.done_res   = (state_in == ST_CAL) && returned_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_INIT;
         count_ff     <= CountWidth'(StallTicks);
         pos_stop_ff  <= '0;
         returned_ff  <= 1'b0;
         cal_ff       <= 1'b0;
         held_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff    <= state_in;
            count_ff    <= count_in;
            pos_stop_ff <= pos_stop_in;
            returned_ff <= returned_in;
            cal_ff      <= cal_in;
            held_ff     <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_cal_phase = (rsp_data_ff.phase == PHASE_CAL);
   assign rsp_has_wr    = rsp_valid_ff && rsp_data_ff.offset_write;
   assign rsp_no_drive  = rsp_valid_ff && (rsp_data_ff.drive_mode == DRIVE_NONE);

   `HSH_ASSERT_NOW(a_offset_sets_cal, rsp_has_wr, rsp_data_ff.calibrated && rsp_cal_phase)
   `HSH_ASSERT_NOW(a_done_needs_cal, rsp_valid_ff && rsp_data_ff.done_res, rsp_cal_phase)
   `HSH_ASSERT_NOW(a_idle_drive_zero, rsp_no_drive, rsp_data_ff.drive_command == '0)
   `HSH_ASSERT_NEXT(a_blocked_item_held, req_stall, in_valid_ff && $stable(in_data_ff))

endmodule

/* tb/sv/hard_stop_homing_checker.sv */
// Checker for the homing sequencer: predicts every result and compares it with the block's output
`timescale 1ns / 1ps

module hard_stop_homing_checker
   import hsh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]   csr_wdata,
   output int                     fault_count,
   output int                     outstanding
);

   logic signed [DataWidth-1:0] search_vel;
   logic        [DataWidth-2:0] stall_lim;
   logic                        center_en;
   logic                        return_en;
   logic signed [DataWidth-1:0] return_tgt;
   logic        [DataWidth-2:0] return_tol;

   logic [1:0]                  phase_now;
   int                          stall_left;
   logic signed [DataWidth-1:0] upper_stop;
   logic                        returned;
   logic                        calibrated;
   logic signed [DataWidth-1:0] held_cmd;

   rsp_type expected_q[$];
   int      faults = 0;

   task automatic mark_calibrated();
      calibrated = 1'b1;
      phase_now  = PHASE_CAL;
      if (!return_en) returned = 1'b1;
   endtask

   task automatic homing_step(input req_type t, output rsp_type r);
      logic [DataWidth-1:0]        mag;
      logic                        slow;
      logic signed [DataWidth:0]   pair_sum;
      logic [DataWidth-1:0]        gap;
      r    = '0;
      mag  = t.joint_speed[DataWidth-1] ? ({DataWidth{1'b0}} - t.joint_speed) : t.joint_speed;
      slow = mag < {1'b0, stall_lim};
      if (t.restart) begin
         phase_now  = PHASE_INIT;
         calibrated = 1'b0;
      end
      case (phase_now)
         PHASE_INIT: begin
            held_cmd   = search_vel;
            stall_left = StallTicks;
            phase_now  = PHASE_POS;
         end
         PHASE_POS: begin
            if (slow && !t.halted) stall_left--;
            else stall_left = StallTicks;
            if (stall_left < 0) begin
               held_cmd = '0;
               if (!center_en) begin
                  r.offset_write = 1'b1;
                  r.new_offset   = t.current_offset - t.actuator_pos;
                  mark_calibrated();
               end else begin
                  upper_stop = t.actuator_pos;
                  stall_left = StallTicks;
                  held_cmd   = {DataWidth{1'b0}} - search_vel;
                  phase_now  = PHASE_NEG;
               end
            end
            r.drive_mode    = DRIVE_VEL;
            r.drive_command = held_cmd;
         end
         PHASE_NEG: begin
            if (slow) stall_left--;
            else stall_left = StallTicks;
            if (stall_left < 0) begin
               held_cmd = '0;
               pair_sum = {upper_stop[DataWidth-1], upper_stop}
                        + {t.actuator_pos[DataWidth-1], t.actuator_pos};
               r.offset_write = 1'b1;
               r.new_offset   = t.current_offset - pair_sum[DataWidth:1];
               mark_calibrated();
            end
            r.drive_mode    = DRIVE_VEL;
            r.drive_command = held_cmd;
         end
         default: begin
            if (return_en) begin
               if (t.joint_pos >= return_tgt) gap = t.joint_pos - return_tgt;
               else gap = return_tgt - t.joint_pos;
               if (gap < {1'b0, return_tol}) returned = 1'b1;
               r.drive_mode    = DRIVE_POS;
               r.drive_command = return_tgt;
            end else begin
               r.drive_mode    = DRIVE_VEL;
               r.drive_command = held_cmd;
            end
         end
      endcase
      r.phase      = phase_now;
      r.calibrated = calibrated;
      r.done_res   = (phase_now == PHASE_CAL) && returned;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         search_vel = '0;
         stall_lim  = '0;
         center_en  = 1'b0;
         return_en  = 1'b0;
         return_tgt = '0;
         return_tol = '0;
         phase_now  = PHASE_INIT;
         stall_left = StallTicks;
         upper_stop = '0;
         returned   = 1'b0;
         calibrated = 1'b0;
         held_cmd   = '0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SEARCH_VEL: search_vel = csr_wdata;
               CSR_STALL_VEL:  stall_lim  = csr_wdata[DataWidth-2:0];
               CSR_CENTER_EN:  center_en  = csr_wdata[0];
               CSR_RETURN_EN:  return_en  = csr_wdata[0];
               CSR_RETURN_TGT: return_tgt = csr_wdata;
               CSR_RETURN_TOL: return_tol = csr_wdata[DataWidth-2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            homing_step(req_data, predicted);
            expected_q.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               faults++;
               if (faults <= 10) $display("unexpected result %h", rsp_data);
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_data.phase !== oldest.phase
                   || rsp_data.drive_mode !== oldest.drive_mode
                   || rsp_data.drive_command !== oldest.drive_command
                   || rsp_data.offset_write !== oldest.offset_write
                   || rsp_data.new_offset !== oldest.new_offset
                   || rsp_data.calibrated !== oldest.calibrated
                   || rsp_data.done_res !== oldest.done_res) begin
                  faults++;
                  if (faults <= 10) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected phase %0d mode %0d cmd %h wr %0d off %h cal %0d done %0d",
                              oldest.phase, oldest.drive_mode, oldest.drive_command,
                              oldest.offset_write, oldest.new_offset, oldest.calibrated,
                              oldest.done_res);
                     $display("  actual   phase %0d mode %0d cmd %h wr %0d off %h cal %0d done %0d",
                              rsp_data.phase, rsp_data.drive_mode, rsp_data.drive_command,
                              rsp_data.offset_write, rsp_data.new_offset, rsp_data.calibrated,
                              rsp_data.done_res);
                  end
               end
            end
         end
      end
      fault_count <= faults;
      outstanding <= expected_q.size();
   end

endmodule

/* tb/sv/tb_hard_stop_homing_sequencer_top.sv */
// Testbench top for the homing sequencer: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_hard_stop_homing_sequencer_top
   import hsh_pkg::*;
();

   localparam int WatchdogLimit = 3000;
   localparam int HoldOffCycles = 200;
   localparam int PhaseItems    = 300;
   localparam int TicksToStall  = StallTicks + 1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [DataWidth-1:0]   csr_wdata = '0;

   int fault_count;
   int outstanding;
   int tx_idle_pct = 35;
   int rx_idle_pct = 59;
   int hold_go     = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int quiet       = 0;
   int items_sent  = 0;

   logic        [DataWidth-2:0] stall_lim  = '0;
   logic        [DataWidth-2:0] tol_now    = '0;
   logic signed [DataWidth-1:0] target_now = '0;
   logic                        center_now = 1'b0;

   initial forever #5 clock = ~clock;

   hard_stop_homing_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hard_stop_homing_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   // hold off the result channel for a long stretch on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_go) begin
         hold_seen <= hold_go;
         hold_left <= HoldOffCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet <= 0;
      end else if (quiet >= WatchdogLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic req_type make_req(input logic restart, input logic [31:0] speed,
                                        input logic [31:0] apos, input logic [31:0] coff,
                                        input logic halted, input logic [31:0] jpos);
      req_type r;
      r.restart        = restart;
      r.joint_speed    = speed;
      r.actuator_pos   = apos;
      r.current_offset = coff;
      r.halted         = halted;
      r.joint_pos      = jpos;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] slow_speed();
      logic [31:0] mag;
      if (stall_lim == 0) return $urandom();
      if ($urandom_range(0, 3) == 0) mag = {1'b0, stall_lim} - 32'd1;
      else mag = $urandom_range(0, {1'b0, stall_lim} - 32'd1);
      return $urandom_range(0, 1) ? 32'd0 - mag : mag;
   endfunction

   function automatic logic [31:0] near_target();
      logic [31:0] d;
      case ($urandom_range(0, 3))
         0: d = {1'b0, tol_now};
         1: d = {1'b0, tol_now} - 32'd1;
         2: d = $urandom_range(0, {1'b0, tol_now});
         default: return $urandom();
      endcase
      return $urandom_range(0, 1) ? target_now + d : target_now - d;
   endfunction

   task automatic send_txn(input req_type item);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx, input logic [DataWidth-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] search, input logic [31:0] stall_word,
                            input logic [31:0] center_word, input logic [31:0] return_word,
                            input logic [31:0] target, input logic [31:0] tol_word);
      drain();
      csr_write(CSR_SEARCH_VEL, search);
      csr_write(CSR_STALL_VEL, stall_word);
      csr_write(CSR_CENTER_EN, center_word);
      csr_write(CSR_RETURN_EN, return_word);
      csr_write(CSR_RETURN_TGT, target);
      csr_write(CSR_RETURN_TOL, tol_word);
      csr_wr_en  <= 1'b0;
      stall_lim  = stall_word[DataWidth-2:0];
      tol_now    = tol_word[DataWidth-2:0];
      target_now = target;
      center_now = center_word[0];
   endtask

   task automatic configure_random();
      logic [31:0] stall_word;
      logic [31:0] tol_word;
      case ($urandom_range(0, 5))
         0: stall_word = 32'hFFFF_FFFF;
         1: stall_word = 32'h8000_0001;
         2: stall_word = $urandom_range(2, 4096);
         default: stall_word = $urandom();
      endcase
      case ($urandom_range(0, 4))
         0: tol_word = 32'h0000_0000;
         1: tol_word = 32'hFFFF_FFFF;
         2: tol_word = $urandom_range(0, 1000);
         default: tol_word = $urandom();
      endcase
      configure(pick_word(), stall_word, $urandom(), $urandom(), pick_word(), tol_word);
   endtask

   task automatic run_homing();
      int abort_at;
      int i;
      int n;
      abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, StallTicks) : 0;
      send_txn(make_req(1'b1, $urandom(), pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                        $urandom()));
      n = $urandom_range(0, 3);
      repeat (n) send_txn(make_req($urandom_range(0, 15) == 0, $urandom(), pick_word(),
                                   pick_word(), 1'($urandom_range(0, 1)), $urandom()));
      // stop one tick short of a stall, then break the run
      if ($urandom_range(0, 5) == 0) begin
         repeat (StallTicks) send_txn(make_req(1'b0, slow_speed(), pick_word(), pick_word(),
                                               1'b0, $urandom()));
         send_txn(make_req(1'b0, $urandom(), pick_word(), pick_word(), 1'b1, $urandom()));
      end
      for (i = 1; i <= TicksToStall; i++)
         send_txn(make_req(i == abort_at, slow_speed(), pick_word(), pick_word(), 1'b0,
                           $urandom()));
      if (center_now) begin
         n = $urandom_range(0, 3);
         repeat (n) send_txn(make_req(1'b0, $urandom(), pick_word(), pick_word(),
                                      1'($urandom_range(0, 1)), $urandom()));
         repeat (TicksToStall) send_txn(make_req(1'b0, slow_speed(), pick_word(), pick_word(),
                                                 1'($urandom_range(0, 1)), $urandom()));
      end
      n = $urandom_range(2, 12);
      repeat (n) send_txn(make_req($urandom_range(0, 15) == 0, $urandom(), pick_word(),
                                   pick_word(), 1'($urandom_range(0, 1)), near_target()));
   endtask

   initial begin : stimulus
      int p;
      int seq;
      int phase_end;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_txn(make_req(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF));
      send_txn(make_req(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h8000_0000));
      send_txn(make_req(1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0));
      send_txn(make_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));

      configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_txn(make_req(1'b1, 32'h0, 32'h1, 32'h2, 1'b0, 32'h0));
      send_txn(make_req(1'b0, 32'h8000_0001, 32'h0, 32'h0, 1'b0, 32'h0));
      send_txn(make_req(1'b0, 32'h7FFF_FFFE, 32'h0, 32'h0, 1'b1, 32'h0));
      send_txn(make_req(1'b0, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0));
      send_txn(make_req(1'b0, 32'h7FFF_FFFE, 32'h0, 32'h0, 1'b0, 32'h0));
      send_txn(make_req(1'b1, 32'h8000_0002, 32'h0, 32'h0, 1'b0, 32'h7FFF_FFFF));

      // negated search stays at the most negative value
      configure(32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h0);
      run_homing();

      for (p = 0; p < 3; p++) begin
         tx_idle_pct  = (p == 0) ? 35 : (p == 1) ? 59 : 0;
         rx_idle_pct <= (p == 0) ? 59 : (p == 1) ? 35 : 0;
         phase_end    = items_sent + PhaseItems;
         seq          = 0;
         while (items_sent < phase_end) begin
            configure_random();
            if (p == 0 && seq == 1) hold_go <= hold_go + 1;
            run_homing();
            seq++;
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
